>>> sv/uv_sphere_vertex_index_gen_top_macros.svh
// Assertion macros used by the UV sphere generator top level.
`ifndef UV_SPHERE_VERTEX_INDEX_GEN_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_INDEX_GEN_TOP_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uvs: assertion failed");

// Next-cycle implication on clk_i, off while rst_ni is low.
`define UVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uvs: assertion failed");

`endif

>>> sv/uvs_pkg.sv
// Types and constants of the UV sphere vertex and index generator.
package uvs_pkg;

  localparam int MAX_GRID        = 255;
  localparam int COORD_FRAC_BITS = 15;

  // Q30 constants for the sine kernel
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int HORNER_TERMS = 8;
  // two argument stages, three per Horner term, one final product
  localparam int SIN_LAT      = 3 * HORNER_TERMS + 3;

  // long division word: 8 integer bits over 32 fraction bits
  localparam int DIV_W   = 40;
  localparam int DIV_REM = 9;

  typedef enum logic [1:0] {
    REG_STACK_COUNT = 2'd0,
    REG_SLICE_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] ring;
    logic [7:0] column;
  } in_t;

  typedef struct packed {
    logic              in_range;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]       tex_u;
    logic [16:0]       tex_v;
    logic              has_quad;
    logic [15:0]       corner_top_left;
    logic [15:0]       corner_top_right;
    logic [15:0]       corner_bottom_left;
    logic [15:0]       corner_bottom_right;
  } out_t;

  typedef struct packed {
    logic [DIV_REM-1:0] rem;
    logic [DIV_W-1:0]   work;
  } div_t;

  typedef struct packed {
    logic        in_range;
    logic        has_quad;
    logic [15:0] corner_a;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  quad_phi;
    logic [1:0]  quad_th;
  } side_t;

endpackage

>>> sv/uvs_sin_pipe.sv
// Pipelined sine of a quadrant remainder (Q32 turns in, Q30 out), Taylor Horner form.
module uvs_sin_pipe (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] r_i,
  output logic [30:0] sin_o
);

  localparam int TERMS = uvs_pkg::HORNER_TERMS;

  logic [30:0] x0_q;
  logic [30:0] x1_q;
  logic [31:0] x2_q;

  logic [31:0] y_q   [TERMS];
  logic [30:0] xa_q  [TERMS];
  logic [31:0] x2a_q [TERMS];
  logic [61:0] m_q   [TERMS];
  logic [31:0] yb_q  [TERMS];
  logic [30:0] xb_q  [TERMS];
  logic [31:0] x2b_q [TERMS];
  logic [30:0] s_q   [TERMS];
  logic [30:0] xc_q  [TERMS];
  logic [31:0] x2c_q [TERMS-1];

  logic [62:0] arg_prod;
  logic [61:0] sq_prod;
  logic [61:0] fin_prod;

  assign arg_prod = 63'(r_i) * 63'(uvs_pkg::PI_Q30);
  assign sq_prod  = 62'(x0_q) * 62'(x0_q);
  assign fin_prod = 62'(xc_q[TERMS-1]) * 62'(s_q[TERMS-1]);

  // radians, then x squared; also the final product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= 31'(arg_prod >> 31);
      x1_q  <= x0_q;
      x2_q  <= 32'(sq_prod >> 30);
      sin_o <= 31'(fin_prod >> 30);
    end
  end

  for (genvar i = 0; i < TERMS; i++) begin : g_term
    localparam int unsigned N  = TERMS - i;
    localparam int unsigned DV = (2 * N) * (2 * N + 1);
    localparam logic [8:0]  DIVISOR = 9'(DV);
    // floor(2^32 / DV): quotient low by at most one, fixed in the last stage
    localparam logic [29:0] RECIP = 30'(64'h1_0000_0000 / 64'(DV));

    logic [30:0] s_prev;
    logic [31:0] x2_prev;
    logic [30:0] x_prev;
    logic [62:0] a_prod;
    logic [61:0] b_prod;
    logic [29:0] q_est;
    logic [31:0] q_rem;
    logic [30:0] q_fix;
    logic [30:0] s_next;

    if (i == 0) begin : g_first
      assign s_prev  = uvs_pkg::Q30_ONE;
      assign x2_prev = x2_q;
      assign x_prev  = x1_q;
    end else begin : g_rest
      assign s_prev  = s_q[i-1];
      assign x2_prev = x2c_q[i-1];
      assign x_prev  = xc_q[i-1];
    end

    assign a_prod = 63'(x2_prev) * 63'(s_prev);
    assign b_prod = 62'(y_q[i]) * 62'(RECIP);
    assign q_est  = m_q[i][61:32];
    assign q_rem  = yb_q[i] - 32'(39'(q_est) * 39'(DIVISOR));
    assign q_fix  = 31'(q_est) + ((q_rem >= 32'(DIVISOR)) ? 31'd1 : 31'd0);
    assign s_next = (q_fix >= uvs_pkg::Q30_ONE) ? 31'd0 : uvs_pkg::Q30_ONE - q_fix;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[i]   <= 32'(a_prod >> 30);
        xa_q[i]  <= x_prev;
        x2a_q[i] <= x2_prev;
        m_q[i]   <= b_prod;
        yb_q[i]  <= y_q[i];
        xb_q[i]  <= xa_q[i];
        x2b_q[i] <= x2a_q[i];
        s_q[i]   <= s_next;
        xc_q[i]  <= xb_q[i];
      end
    end

    if (i < TERMS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x2c_q[i] <= x2b_q[i];
        end
      end
    end else begin : g_last
      logic unused_x2;
      assign unused_x2 = ^x2b_q[i];
    end
  end

endmodule

>>> sv/uv_sphere_vertex_index_gen_top.sv
// Top level of the UV sphere vertex and index generator.
//
// One grid point (ring, column) in, one vertex word out: unit-sphere position in
// Q1.15 (rounded, saturated), texture u and 1-v in Q1.16, and when the point
// starts a quad its four corner indices (triangles a,c,d and a,d,b). Points off
// the grid come back with in_range low and every other field zero. The block is
// a 41-stage pipeline taking one word per cycle unless a finished word is held.
// The depth is set by the four 40-bit long divisions (phase of phi and theta,
// tex u and v), retired four quotient bits per stage over ten stages, and by
// the sine kernels, which spend three stages (multiply, reciprocal multiply,
// correct) on each of eight Horner terms. The whole pipeline holds when the
// output word is not taken, so a stall loses or repeats nothing. The user must
// write stack_count and slice_count through the plain write port only while no
// word is in flight; the block does not enforce it. Zero acts as one.
`include "uv_sphere_vertex_index_gen_top_macros.svh"

module uv_sphere_vertex_index_gen_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  uvs_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uvs_pkg::out_t      out_data_o
);

  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = uvs_pkg::DIV_W / DIV_BITS;
  localparam int ST_Q       = DIV_STAGES + 1;
  localparam int ST_SIN     = ST_Q + uvs_pkg::SIN_LAT;
  localparam int ST_MUL     = ST_SIN + 1;
  localparam int NSTG       = ST_MUL + 2;
  localparam int SH         = 60 - uvs_pkg::COORD_FRAC_BITS;
  localparam int LANES      = 4;   // phi, theta, tex u, tex v

  // configuration registers
  logic [7:0] stack_q;
  logic [7:0] slice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q <= 8'd16;
      slice_q <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvs_pkg::REG_STACK_COUNT: stack_q <= cfg_data_i;
        uvs_pkg::REG_SLICE_COUNT: slice_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] eff_count(logic [7:0] n);
    logic [7:0] r;
    r = (n == 8'd0) ? 8'd1 : n;
    if (32'(r) > uvs_pkg::MAX_GRID) r = 8'(uvs_pkg::MAX_GRID);
    return r;
  endfunction

  // user keeps counts stable while words in flight (unenforced); read directly
  logic [7:0] stacks;
  logic [7:0] slices;
  logic [8:0] cols;
  logic [8:0] dvsr [LANES];

  assign stacks  = eff_count(stack_q);
  assign slices  = eff_count(slice_q);
  assign cols    = 9'(slices) + 9'd1;
  assign dvsr[0] = {stacks, 1'b0};
  assign dvsr[1] = 9'(slices);
  assign dvsr[2] = 9'(slices);
  assign dvsr[3] = 9'(stacks);

  // global advance: everything moves unless a finished word is held
  logic            en;
  logic [NSTG-1:0] v_q;

  assign en          = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // restoring long division, DIV_BITS quotient bits per call
  function automatic uvs_pkg::div_t div_steps(uvs_pkg::div_t cur, logic [8:0] d);
    logic [9:0]     t;
    uvs_pkg::div_t  nx;
    nx = cur;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {nx.rem, nx.work[uvs_pkg::DIV_W-1]};
      nx.work = {nx.work[uvs_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        nx.rem     = 9'(t - {1'b0, d});
        nx.work[0] = 1'b1;
      end else begin
        nx.rem = t[8:0];
      end
    end
    return nx;
  endfunction

  // capture stage: numerators with the rounding term, grid checks, corner a
  uvs_pkg::div_t dv_q [LANES][DIV_STAGES+1];
  uvs_pkg::side_t side_q [ST_MUL+1];
  uvs_pkg::side_t side_cap;
  logic [uvs_pkg::DIV_W-1:0] num_cap [LANES];

  always_comb begin
    num_cap[0] = {in_data_i.ring, 32'd0} | 40'(stacks);
    num_cap[1] = {in_data_i.column, 32'd0} | 40'(slices >> 1);
    num_cap[2] = 40'({in_data_i.column, 16'd0} | 24'(slices >> 1));
    num_cap[3] = 40'({in_data_i.ring, 16'd0} | 24'(stacks >> 1));
    side_cap          = '0;
    side_cap.in_range = (in_data_i.ring <= stacks) && (in_data_i.column <= slices);
    side_cap.has_quad = (in_data_i.ring < stacks) && (in_data_i.column < slices);
    side_cap.corner_a = 16'(17'(in_data_i.ring) * 17'(cols) + 17'(in_data_i.column));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_cap;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[l][0] <= '{rem: '0, work: num_cap[l]};
      end
    end
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[l][k] <= div_steps(dv_q[l][k-1], dvsr[l]);
        end
      end
    end
  end

  // quadrant split: sine and cosine arguments for phi and theta
  logic [31:0] ph_phi;
  logic [31:0] ph_th;
  logic [30:0] rarg_q [LANES];
  logic [30:0] sin_w  [LANES];

  assign ph_phi = dv_q[0][DIV_STAGES].work[31:0];
  assign ph_th  = dv_q[1][DIV_STAGES].work[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rarg_q[0] <= {1'b0, ph_phi[29:0]};
      rarg_q[1] <= uvs_pkg::Q30_ONE - {1'b0, ph_phi[29:0]};
      rarg_q[2] <= {1'b0, ph_th[29:0]};
      rarg_q[3] <= uvs_pkg::Q30_ONE - {1'b0, ph_th[29:0]};
    end
  end

  for (genvar k = 1; k <= ST_MUL; k++) begin : g_side
    if (k == ST_Q) begin : g_fill
      uvs_pkg::side_t fill_d;

      always_comb begin
        fill_d          = side_q[k-1];
        fill_d.tex_u    = dv_q[2][DIV_STAGES].work[16:0];
        fill_d.tex_v    = 17'h1_0000 - dv_q[3][DIV_STAGES].work[16:0];
        fill_d.quad_phi = ph_phi[31:30];
        fill_d.quad_th  = ph_th[31:30];
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          side_q[k] <= fill_d;
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk_i) begin
        if (en) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_sin
    uvs_sin_pipe u_sin (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (rarg_q[l]),
      .sin_o (sin_w[l])
    );
  end

  // quadrant signs, then the Q60 products
  logic [30:0] sp, cp, st, ct;
  logic        sp_n, cp_n, st_n, ct_n;
  logic [61:0] mag_x_q, mag_y_q, mag_z_q;
  logic        neg_x_q, neg_y_q, neg_z_q;

  always_comb begin
    case (side_q[ST_SIN].quad_phi)
      2'd0:    begin sp = sin_w[0]; sp_n = 1'b0; cp = sin_w[1]; cp_n = 1'b0; end
      2'd1:    begin sp = sin_w[1]; sp_n = 1'b0; cp = sin_w[0]; cp_n = 1'b1; end
      2'd2:    begin sp = sin_w[0]; sp_n = 1'b1; cp = sin_w[1]; cp_n = 1'b1; end
      default: begin sp = sin_w[1]; sp_n = 1'b1; cp = sin_w[0]; cp_n = 1'b0; end
    endcase
    case (side_q[ST_SIN].quad_th)
      2'd0:    begin st = sin_w[2]; st_n = 1'b0; ct = sin_w[3]; ct_n = 1'b0; end
      2'd1:    begin st = sin_w[3]; st_n = 1'b0; ct = sin_w[2]; ct_n = 1'b1; end
      2'd2:    begin st = sin_w[2]; st_n = 1'b1; ct = sin_w[3]; ct_n = 1'b1; end
      default: begin st = sin_w[3]; st_n = 1'b1; ct = sin_w[2]; ct_n = 1'b0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_x_q <= 62'(sp) * 62'(ct);
      mag_y_q <= 62'(sp) * 62'(st);
      mag_z_q <= {1'b0, cp, 30'd0};
      neg_x_q <= sp_n ^ ct_n;
      neg_y_q <= sp_n ^ st_n;
      neg_z_q <= cp_n;
    end
  end

  // round half away from zero, then saturate to 16-bit signed
  function automatic logic signed [15:0] to_coord(logic neg, logic [61:0] mag);
    logic [63:0] sum;
    logic [63:0] m;
    sum = 64'(mag) + (64'd1 << (SH - 1));
    m   = sum >> SH;
    if (neg) begin
      if (m > 64'd32768) m = 64'd32768;
      return 16'(64'd0 - m);
    end
    if (m > 64'd32767) m = 64'd32767;
    return 16'(m);
  endfunction

  uvs_pkg::out_t  out_q;
  uvs_pkg::out_t  out_d;
  uvs_pkg::side_t sd;
  logic [15:0]    corner_c;

  assign sd       = side_q[ST_MUL];
  assign corner_c = sd.corner_a + 16'(cols);

  always_comb begin
    out_d = '0;
    if (sd.in_range) begin
      out_d.in_range = 1'b1;
      out_d.pos_x    = to_coord(neg_x_q, mag_x_q);
      out_d.pos_y    = to_coord(neg_y_q, mag_y_q);
      out_d.pos_z    = to_coord(neg_z_q, mag_z_q);
      out_d.tex_u    = sd.tex_u;
      out_d.tex_v    = sd.tex_v;
    end
    if (sd.has_quad) begin
      out_d.has_quad            = 1'b1;
      out_d.corner_top_left     = sd.corner_a;
      out_d.corner_top_right    = sd.corner_a + 16'd1;
      out_d.corner_bottom_left  = corner_c;
      out_d.corner_bottom_right = corner_c + 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  `UVS_ASSERT_IMP(a_off_grid_zero, out_valid_o && !out_q.in_range, out_q.pos_x == 16'sd0 && out_q.pos_z == 16'sd0 && out_q.tex_u == 17'd0 && out_q.tex_v == 17'd0)
  `UVS_ASSERT_IMP(a_quad_on_grid, out_valid_o && out_q.has_quad, out_q.in_range && out_q.corner_bottom_right == out_q.corner_bottom_left + 16'd1)
  `UVS_ASSERT_IMP(a_tex_bounded, out_valid_o && out_q.in_range, out_q.tex_u <= 17'h1_0000 && out_q.tex_v <= 17'h1_0000)
  `UVS_ASSERT_NXT(a_stall_freezes, !en, v_q == $past(v_q))

endmodule

>>> tb/sv/uvs_vertex_checker.sv
// Vertex checker: watches both channels, predicts each vertex word and compares.
module uvs_vertex_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  uvs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  uvs_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] PI30  = 64'd3373259426;

  logic [7:0]    stacks_q, slices_q;
  uvs_pkg::out_t vertex_q[$];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = vertex_q.size();

  function automatic logic [63:0] clamp_count(logic [7:0] r);
    logic [63:0] n;
    n = r;
    if (n == 0) n = 1;
    if (n > uvs_pkg::MAX_GRID) n = uvs_pkg::MAX_GRID;
    return n;
  endfunction

  function automatic logic [63:0] quarter_sine(logic [63:0] r);
    logic [63:0] x, x2, s, t;
    x  = (r * PI30) >> 31;
    x2 = (x * x) >> 30;
    s  = ONE30;
    for (int n = 8; n >= 1; n--) begin
      t = ((x2 * s) >> 30) / ((2 * n) * (2 * n + 1));
      s = (t >= ONE30) ? 64'd0 : ONE30 - t;
    end
    return (x * s) >> 30;
  endfunction

  // sin/cos magnitudes and signs of a phase in Q32 turns
  function automatic void phase_sincos(input logic [63:0] ph, output logic sn,
                                       output logic [63:0] sm, output logic cn,
                                       output logic [63:0] cm);
    logic [1:0]  q;
    logic [63:0] r, s, c;
    q = ph[31:30];
    r = ph & (ONE30 - 1);
    s = quarter_sine(r);
    c = quarter_sine(ONE30 - r);
    case (q)
      2'd0: begin sm = s; sn = 0; cm = c; cn = 0; end
      2'd1: begin sm = c; sn = 0; cm = s; cn = 1; end
      2'd2: begin sm = s; sn = 1; cm = c; cn = 1; end
      default: begin sm = c; sn = 1; cm = s; cn = 0; end
    endcase
  endfunction

  function automatic logic [15:0] q60_to_coord(logic neg, logic [63:0] mag);
    logic [63:0] m;
    m = (mag + (64'd1 << (59 - uvs_pkg::COORD_FRAC_BITS))) >> (60 - uvs_pkg::COORD_FRAC_BITS);
    if (m == 0) return 16'd0;
    if (neg) begin
      if (m > 32768) m = 32768;
      return 16'(64'd0 - m);
    end
    if (m > 32767) m = 32767;
    return m[15:0];
  endfunction

  function automatic uvs_pkg::out_t vertex_of(uvs_pkg::in_t pt, logic [7:0] st_r,
                                              logic [7:0] sl_r);
    uvs_pkg::out_t v;
    logic [63:0]   st, sl, rg, cl, pphi, pth, sp, cp, sth, cth, a, c, cols;
    logic          spn, cpn, stn, ctn;
    v  = '0;
    st = clamp_count(st_r);
    sl = clamp_count(sl_r);
    rg = pt.ring;
    cl = pt.column;
    if (rg > st || cl > sl) return v;
    v.in_range = 1'b1;
    pphi = ((rg << 32) + st) / (2 * st);
    pth  = (((cl << 32) + sl / 2) / sl) & 64'hFFFF_FFFF;
    phase_sincos(pphi, spn, sp, cpn, cp);
    phase_sincos(pth, stn, sth, ctn, cth);
    v.pos_x = q60_to_coord(spn != ctn, sp * cth);
    v.pos_y = q60_to_coord(spn != stn, sp * sth);
    v.pos_z = q60_to_coord(cpn, cp << 30);
    v.tex_u = 17'(((cl << 16) + sl / 2) / sl);
    v.tex_v = 17'(64'd65536 - ((rg << 16) + st / 2) / st);
    if (rg < st && cl < sl) begin
      cols = sl + 1;
      a    = rg * cols + cl;
      c    = a + cols;
      v.has_quad            = 1'b1;
      v.corner_top_left     = a[15:0];
      v.corner_top_right    = 16'(a + 1);
      v.corner_bottom_left  = c[15:0];
      v.corner_bottom_right = 16'(c + 1);
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    uvs_pkg::out_t exp_v;
    if (!rst_ni) begin
      stacks_q <= 8'd16;
      slices_q <= 8'd32;
      fails    <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == uvs_pkg::REG_STACK_COUNT) stacks_q <= cfg_data_i;
        else if (cfg_idx_i == uvs_pkg::REG_SLICE_COUNT) slices_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        vertex_q.insert(vertex_q.size(), vertex_of(in_data_i, stacks_q, slices_q));
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          if (fails < 10) $display("unexpected vertex word %h", out_data_i);
          fails <= fails + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (exp_v !== out_data_i) begin
            if (fails < 10) begin
              $display("vertex mismatch: exp %h got %h", exp_v, out_data_i);
              $display("  pos exp %0d %0d %0d got %0d %0d %0d", exp_v.pos_x, exp_v.pos_y,
                       exp_v.pos_z, out_data_i.pos_x, out_data_i.pos_y, out_data_i.pos_z);
            end
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// Testbench top: stimulus, idling phases and verdict for the UV sphere generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 41;
  localparam int WATCHDOG  = 5000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = '0;
  logic [7:0]    cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  uvs_pkg::in_t  in_data_i = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o, out_valid_o;
  uvs_pkg::out_t out_data_o;
  int            fail_count, pending;

  // idle percentages for sender and receiver; hold_rx forces a long stall
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       hold_rx = 1'b0;
  logic [7:0] cur_stacks = 8'd16, cur_slices = 8'd32;

  uv_sphere_vertex_index_gen_top uut (.*);

  uvs_vertex_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i,
    .in_ready_i(in_ready_o), .in_data_i, .out_valid_i(out_valid_o), .out_ready_i,
    .out_data_i(out_data_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls per phase, plus the forced hold-off.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: cycles with no word moving on either channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word, waiting out the sender's idle gap; returns once in_ready_o is seen high.
  // Valid stays up on return; the next word or an explicit drop clears it.
  task automatic send_word(input logic [7:0] ring, input logic [7:0] column);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{ring: ring, column: column};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Registers are only touched once the pipeline has drained.
  task automatic write_counts(input logic [7:0] st, input logic [7:0] sl);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= uvs_pkg::REG_STACK_COUNT;
    cfg_data_i <= st;
    @(posedge clk_i);
    cfg_idx_i  <= uvs_pkg::REG_SLICE_COUNT;
    cfg_data_i <= sl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_stacks = st;
    cur_slices = sl;
  endtask

  // Mostly grid points (clamped count), some on or just past the edge, some noise.
  task automatic send_random;
    int st, sl;
    int pick;
    st = (cur_stacks == 0) ? 1 : cur_stacks;
    sl = (cur_slices == 0) ? 1 : cur_slices;
    pick = $urandom_range(99);
    if (pick < 80)
      send_word(8'($urandom_range(st)), 8'($urandom_range(sl)));
    else if (pick < 90)
      send_word(8'($urandom_range(255)), 8'($urandom_range(255)));
    else
      send_word(8'(st + $urandom_range(1)), 8'(sl + $urandom_range(1)));
  endtask

  initial begin
    // count settings: extremes, zero, reset values and a few typical meshes
    logic [7:0] cfg_st[8] = '{8'd255, 8'd1, 8'd0, 8'd16, 8'd7, 8'd255, 8'd3, 8'd100};
    logic [7:0] cfg_sl[8] = '{8'd255, 8'd0, 8'd1, 8'd32, 8'd255, 8'd5, 8'd12, 8'd64};
    int phase_tx[4] = '{0, 80, 0, 18};
    int phase_rx[4] = '{0, 0, 80, 18};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset counts, poles, seam, corners, off-grid, all-ones fields
    send_word(8'd0, 8'd0);
    send_word(8'd16, 8'd32);
    send_word(8'd16, 8'd0);
    send_word(8'd0, 8'd32);
    send_word(8'd15, 8'd31);
    send_word(8'd8, 8'd8);
    send_word(8'd8, 8'd16);
    send_word(8'd8, 8'd24);
    send_word(8'd4, 8'd4);
    send_word(8'd17, 8'd0);
    send_word(8'd0, 8'd33);
    send_word(8'd255, 8'd255);
    send_word(8'd170, 8'd85);
    write_counts(8'd255, 8'd255);
    send_word(8'd254, 8'd254);
    send_word(8'd255, 8'd255);
    send_word(8'd255, 8'd0);
    send_word(8'd0, 8'd255);
    send_word(8'd127, 8'd128);
    write_counts(8'd0, 8'd0);
    send_word(8'd0, 8'd0);
    send_word(8'd1, 8'd1);
    send_word(8'd0, 8'd1);
    send_word(8'd2, 8'd0);

    // random: each count setting run under each idling phase
    for (int c = 0; c < 8; c++) begin
      write_counts(cfg_st[c], cfg_sl[c]);
      for (int p = 0; p < 4; p++) begin
        tx_idle_pct = phase_tx[p];
        rx_idle_pct = phase_rx[p];
        for (int i = 0; i < 58; i++) send_random();
      end
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end

    // long receiver hold-off while the sender keeps offering words
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_random();
    join
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/uvs_pkg.sv
sv/uvs_sin_pipe.sv
sv/uv_sphere_vertex_index_gen_top.sv
tb/sv/uvs_vertex_checker.sv
tb/sv/tb_top.sv
